@@ rtl/core/ihex_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants of the HEX record parser
// Line phases, run states, result kinds, error codes, record types and the
// character decode used by the parser core.
// ----------------------------------------------------------------------------
package ihex_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SKIP = 2'd1,
		PH_HEX  = 2'd2,
		PH_EOL  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_HALT = 2'd1,
		ST_DONE = 2'd2
	} run_t;

	typedef enum logic [2:0] {
		K_DATA  = 3'd0,
		K_START = 3'd1,
		K_OK    = 3'd2,
		K_ERROR = 3'd3,
		K_EOF   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE   = 3'd0,
		E_HEX    = 3'd1,
		E_SUM    = 3'd2,
		E_EOL    = 3'd3,
		E_LENGTH = 3'd4,
		E_OFFSET = 3'd5,
		E_TYPE   = 3'd6,
		E_SHORT  = 3'd7
	} err_t;

	localparam logic [2:0] REC_DATA      = 3'd0;
	localparam logic [2:0] REC_EOF       = 3'd1;
	localparam logic [2:0] REC_EXT_SEG   = 3'd2;
	localparam logic [2:0] REC_START_SEG = 3'd3;
	localparam logic [2:0] REC_EXT_LIN   = 3'd4;
	localparam logic [2:0] REC_START_LIN = 3'd5;
	localparam logic [2:0] REC_UNKNOWN   = 3'd7;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} nibble_t;

	function automatic nibble_t hex_decode(input logic [7:0] c);
		nibble_t r;
		r.ok  = 1'b1;
		r.val = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/ihex_skid.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_skid: input register with skid entry
// Registers each character and holds one more while the core is blocked, so
// the upstream stall comes straight from a flop.
// ----------------------------------------------------------------------------
module ihex_skid (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       char_valid,
	output logic            char_stall,
	input  wire logic [7:0] text_char,
	output logic            head_valid,
	output logic [7:0]      head_char,
	input  wire logic       head_take
);

	logic       main_valid_q;
	logic [7:0] main_char_q;
	logic       skid_valid_q;
	logic [7:0] skid_char_q;
	logic       accept;

	assign char_stall = skid_valid_q;
	assign accept     = char_valid && !skid_valid_q;
	assign head_valid = main_valid_q;
	assign head_char  = main_char_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_take) begin
			// advance: skid entry moves up, else take the new word
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= accept;
			end
		end else if (accept) begin
			if (!main_valid_q) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_take) begin
			main_char_q <= skid_valid_q ? skid_char_q : text_char;
		end else if (accept && !main_valid_q) begin
			main_char_q <= text_char;
		end
		if (accept && main_valid_q && !head_take) begin
			skid_char_q <= text_char;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/ihex_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_parse: record state machine and result register
// Decodes one character per cycle unless its result waits for a full output
// register, updates the record state and loads at most one result into it.
// ----------------------------------------------------------------------------
module ihex_parse (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  wire logic [7:0] head_char,
	output logic            head_take,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [2:0]      kind,
	output logic [31:0]     address,
	output logic [7:0]      data_byte,
	output logic [2:0]      error_code
);

	ihex_pkg::phase_t phase_q, phase_d;
	ihex_pkg::run_t   stop_q, stop_d;
	logic             nib_q, nib_d;
	logic [3:0]       hi_q, hi_d;
	logic [8:0]       pos_q, pos_d;
	logic [7:0]       len_q, len_d;
	logic [15:0]      off_q, off_d;
	logic [2:0]       typ_q, typ_d;
	logic [7:0]       sum_q, sum_d;
	logic [31:0]      pw_q, pw_d;
	logic [31:0]      base_q, base_d;
	logic             seg_q, seg_d;

	logic              res_v;
	ihex_pkg::kind_t   res_kind;
	logic [31:0]       res_addr;
	logic [7:0]        res_data;
	ihex_pkg::err_t    res_err;

	ihex_pkg::nibble_t hv;
	logic [7:0]        b;
	logic [7:0]        sum_b;
	logic [8:0]        idx;
	logic [15:0]       seg_off;
	logic [7:0]        need;
	logic              type_ok;

	logic              out_valid_q;
	ihex_pkg::kind_t   out_kind_q;
	logic [31:0]       out_addr_q;
	logic [7:0]        out_data_q;
	ihex_pkg::err_t    out_err_q;
	logic              out_free;

	assign hv      = ihex_pkg::hex_decode(head_char);
	assign b       = {hi_q, hv.val};
	assign sum_b   = sum_q + b;
	assign idx     = pos_q - 9'd4;
	assign seg_off = off_q + {7'd0, idx};

	always_comb begin
		need    = 8'd0;
		type_ok = 1'b1;
		unique case (typ_q)
			ihex_pkg::REC_EOF:       need = 8'd0;
			ihex_pkg::REC_EXT_SEG:   need = 8'd2;
			ihex_pkg::REC_START_SEG: need = 8'd4;
			ihex_pkg::REC_EXT_LIN:   need = 8'd2;
			ihex_pkg::REC_START_LIN: need = 8'd4;
			default:                 type_ok = 1'b0;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		stop_d   = stop_q;
		nib_d    = nib_q;
		hi_d     = hi_q;
		pos_d    = pos_q;
		len_d    = len_q;
		off_d    = off_q;
		typ_d    = typ_q;
		sum_d    = sum_q;
		pw_d     = pw_q;
		base_d   = base_q;
		seg_d    = seg_q;
		res_v    = 1'b0;
		res_kind = ihex_pkg::K_DATA;
		res_addr = 32'd0;
		res_data = 8'd0;
		res_err  = ihex_pkg::E_NONE;
		if (stop_q == ihex_pkg::ST_RUN) begin
			unique case (phase_q)
				ihex_pkg::PH_IDLE: begin
					if (head_char == ihex_pkg::CH_COLON) begin
						phase_d = ihex_pkg::PH_HEX;
						nib_d   = 1'b0;
						hi_d    = 4'd0;
						pos_d   = 9'd0;
						len_d   = 8'd0;
						off_d   = 16'd0;
						typ_d   = ihex_pkg::REC_DATA;
						sum_d   = 8'd0;
						pw_d    = 32'd0;
					end else if (head_char != ihex_pkg::CH_NL) begin
						phase_d = ihex_pkg::PH_SKIP;
					end
				end
				ihex_pkg::PH_SKIP: begin
					if (head_char == ihex_pkg::CH_NL) begin
						phase_d = ihex_pkg::PH_IDLE;
					end
				end
				ihex_pkg::PH_EOL: begin
					res_v   = 1'b1;
					phase_d = ihex_pkg::PH_IDLE;
					if (head_char != ihex_pkg::CH_NL) begin
						res_kind = ihex_pkg::K_ERROR;
						res_err  = ihex_pkg::E_EOL;
						stop_d   = ihex_pkg::ST_HALT;
					end else if (typ_q == ihex_pkg::REC_DATA) begin
						res_kind = ihex_pkg::K_OK;
					end else if (!type_ok) begin
						res_kind = ihex_pkg::K_ERROR;
						res_err  = ihex_pkg::E_TYPE;
						stop_d   = ihex_pkg::ST_HALT;
					end else if (len_q != need) begin
						res_kind = ihex_pkg::K_ERROR;
						res_err  = ihex_pkg::E_LENGTH;
						stop_d   = ihex_pkg::ST_HALT;
					end else if (off_q != 16'd0) begin
						res_kind = ihex_pkg::K_ERROR;
						res_err  = ihex_pkg::E_OFFSET;
						stop_d   = ihex_pkg::ST_HALT;
					end else begin
						unique case (typ_q)
							ihex_pkg::REC_EOF: begin
								res_kind = ihex_pkg::K_EOF;
								stop_d   = ihex_pkg::ST_DONE;
							end
							ihex_pkg::REC_EXT_SEG: begin
								res_kind = ihex_pkg::K_OK;
								base_d   = {12'd0, pw_q[15:0], 4'd0};
								seg_d    = 1'b1;
							end
							ihex_pkg::REC_START_SEG: begin
								res_kind = ihex_pkg::K_START;
								res_addr = {12'd0, pw_q[31:16], 4'd0} + {16'd0, pw_q[15:0]};
							end
							ihex_pkg::REC_EXT_LIN: begin
								res_kind = ihex_pkg::K_OK;
								base_d   = {pw_q[15:0], 16'd0};
								seg_d    = 1'b0;
							end
							default: begin
								res_kind = ihex_pkg::K_START;
								res_addr = pw_q;
							end
						endcase
					end
				end
				default: begin
					if (head_char == ihex_pkg::CH_NL || !hv.ok) begin
						res_v    = 1'b1;
						res_kind = ihex_pkg::K_ERROR;
						res_err  = (head_char == ihex_pkg::CH_NL) ? ihex_pkg::E_SHORT
							: ihex_pkg::E_HEX;
						stop_d   = ihex_pkg::ST_HALT;
						phase_d  = ihex_pkg::PH_IDLE;
					end else if (!nib_q) begin
						hi_d  = hv.val;
						nib_d = 1'b1;
					end else begin
						nib_d = 1'b0;
						sum_d = sum_b;
						pos_d = pos_q + 9'd1;
						if (pos_q == 9'd0) begin
							len_d = b;
						end else if (pos_q == 9'd1) begin
							off_d = {b, 8'd0};
						end else if (pos_q == 9'd2) begin
							off_d = {off_q[15:8], b};
						end else if (pos_q == 9'd3) begin
							typ_d = (b > 8'd5) ? ihex_pkg::REC_UNKNOWN : b[2:0];
						end else if (pos_q < 9'd4 + {1'b0, len_q}) begin
							// payload byte: keep the first four for the special records
							if (idx < 9'd4) begin
								pw_d = {pw_q[23:0], b};
							end
							if (typ_q == ihex_pkg::REC_DATA) begin
								res_v    = 1'b1;
								res_kind = ihex_pkg::K_DATA;
								res_data = b;
								res_addr = seg_q ? base_q + {16'd0, seg_off}
									: base_q + {16'd0, off_q} + {23'd0, idx};
							end
						end else if (sum_b != 8'd0) begin
							res_v    = 1'b1;
							res_kind = ihex_pkg::K_ERROR;
							res_err  = ihex_pkg::E_SUM;
							stop_d   = ihex_pkg::ST_HALT;
							phase_d  = ihex_pkg::PH_IDLE;
						end else begin
							phase_d = ihex_pkg::PH_EOL;
						end
					end
				end
			endcase
		end
	end

	// a word with a result waits for room in the output register
	assign out_free  = !out_valid_q || !result_stall;
	assign head_take = head_valid && (!res_v || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ihex_pkg::PH_IDLE;
			stop_q  <= ihex_pkg::ST_RUN;
			nib_q   <= 1'b0;
			hi_q    <= 4'd0;
			pos_q   <= 9'd0;
			len_q   <= 8'd0;
			off_q   <= 16'd0;
			typ_q   <= ihex_pkg::REC_DATA;
			sum_q   <= 8'd0;
			pw_q    <= 32'd0;
			base_q  <= 32'd0;
			seg_q   <= 1'b0;
		end else if (head_take) begin
			phase_q <= phase_d;
			stop_q  <= stop_d;
			nib_q   <= nib_d;
			hi_q    <= hi_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			off_q   <= off_d;
			typ_q   <= typ_d;
			sum_q   <= sum_d;
			pw_q    <= pw_d;
			base_q  <= base_d;
			seg_q   <= seg_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= head_take && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && head_take && res_v) begin
			out_kind_q <= res_kind;
			out_addr_q <= res_addr;
			out_data_q <= res_data;
			out_err_q  <= res_err;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = out_kind_q;
	assign address      = out_addr_q;
	assign data_byte    = out_data_q;
	assign error_code   = out_err_q;

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == ihex_pkg::K_ERROR) |-> stop_q == ihex_pkg::ST_HALT)
		else $error("error result without halt");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(stop_q != ihex_pkg::ST_RUN) |=> $stable(stop_q))
		else $error("run state left halt or end of file");

	a_quiet_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(stop_q != ihex_pkg::ST_RUN && !out_valid_q) |=> !out_valid_q)
		else $error("result produced after stop");

	a_nibble_in_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(stop_q == ihex_pkg::ST_RUN && nib_q) |-> phase_q == ihex_pkg::PH_HEX)
		else $error("pending nibble outside hex digits");

endmodule
`default_nettype wire

@@ rtl/core/intel_hex_record_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// intel_hex_record_parser: streaming HEX record parser
// Character in, data bytes with addresses and per-line status out.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle, sustained; an accepted character is held in the
// input register, and its result is loaded into the output register. Each
// character updates the record state in a single registered step; the only
// thing that holds the input back is a held output register, and a two-entry
// input buffer absorbs that so char_stall comes from a flop. Data bytes leave
// before the line's checksum is known: commit a line's bytes only when its
// closing status word is line ok (kind 2). After an error word the block stays
// silent until reset; after an end-of-file word it ignores all further input.
module intel_hex_record_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire logic [7:0]  text_char,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       kind,
	output logic [31:0]      address,
	output logic [7:0]       data_byte,
	output logic [2:0]       error_code
);

	logic       head_valid;
	logic [7:0] head_char;
	logic       head_take;

	ihex_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.text_char  (text_char),
		.head_valid (head_valid),
		.head_char  (head_char),
		.head_take  (head_take)
	);

	ihex_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_char    (head_char),
		.head_take    (head_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.address      (address),
		.data_byte    (data_byte),
		.error_code   (error_code)
	);

endmodule
`default_nettype wire
